[sv/ssnf_pkg.sv]
package ssnf_pkg;

	localparam int DIGITS_DEF      = 2;
	localparam int MINUS_DIGIT_DEF = 1;
	localparam int ERROR_DIGIT_DEF = 0;
	localparam int MESSAGES_DEF    = 4;

	localparam int NUM_W   = 16;
	localparam int BASE_W  = 5;
	localparam int MSG_W   = 3;
	localparam int REQ_W   = 3;
	localparam int CIDX_W  = 3;
	localparam int STEP_W  = 4;

	localparam logic [REQ_W-1:0] REQ_SHOW    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_MESSAGE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_LAMP    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SET_ERR = 3'd4;

	localparam logic [CIDX_W-1:0] CFG_ACTIVE_HIGH   = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_HEX_DIGITS    = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_SPECIAL_GUARD = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_CODE_ONE_MIN  = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_CODE_ONE_Q    = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_CODE_ALL_MIN  = 3'd5;

	localparam logic [6:0] PAT_BLANK    = 7'h00;
	localparam logic [6:0] PAT_MINUS    = 7'h40;
	localparam logic [6:0] PAT_QUESTION = 7'h53;
	localparam logic [6:0] PAT_ALL      = 7'h7F;

	// microprogram addresses
	localparam logic [STEP_W-1:0] A_LOAD     = 4'd0;
	localparam logic [STEP_W-1:0] A_DISPATCH = 4'd1;
	localparam logic [STEP_W-1:0] A_BLANK    = 4'd2;
	localparam logic [STEP_W-1:0] A_DIV      = 4'd3;
	localparam logic [STEP_W-1:0] A_DIGIT    = 4'd4;
	localparam logic [STEP_W-1:0] A_FITCHK   = 4'd5;
	localparam logic [STEP_W-1:0] A_SIGN     = 4'd6;
	localparam logic [STEP_W-1:0] A_OVF      = 4'd7;
	localparam logic [STEP_W-1:0] A_SPECIAL  = 4'd8;
	localparam logic [STEP_W-1:0] A_MESSAGE  = 4'd9;
	localparam logic [STEP_W-1:0] A_LAMP     = 4'd10;
	localparam logic [STEP_W-1:0] A_CLEAR    = 4'd11;
	localparam logic [STEP_W-1:0] A_SET_ERR  = 4'd12;
	localparam logic [STEP_W-1:0] A_UNKNOWN  = 4'd13;
	localparam logic [STEP_W-1:0] A_EMIT     = 4'd14;
	localparam logic [STEP_W-1:0] A_SPARE    = 4'd15;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_BLANK,
		OP_DIV,
		OP_DIGIT,
		OP_SIGN,
		OP_OVF,
		OP_SPECIAL,
		OP_MESSAGE,
		OP_LAMP,
		OP_CLEAR,
		OP_SET_ERR,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_ACCEPT,
		J_DISPATCH,
		J_COND,
		J_JUMP,
		J_EMIT
	} jmp_t;

	typedef enum logic [1:0] {
		C_SPECIAL,
		C_DIV_MORE,
		C_MORE_DIGITS,
		C_OVF
	} cond_t;

	typedef struct packed {
		op_t               op;
		jmp_t              jmp;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} cword_t;

	typedef struct packed {
		op_t  op;
		logic fire;
	} ctrl_t;

	typedef struct packed {
		logic             special;
		logic             div_last;
		logic             more_digits;
		logic             ovf;
		logic             out_full;
		logic [REQ_W-1:0] req;
	} stat_t;

	function automatic logic [7:0] polar(input logic [6:0] lit, input logic active_high);
		polar = active_high ? {1'b0, lit} : {1'b0, ~lit};
	endfunction

	function automatic logic [6:0] glyph(input logic [3:0] d);
		unique case (d)
			4'h0: glyph = 7'h3F;
			4'h1: glyph = 7'h06;
			4'h2: glyph = 7'h5B;
			4'h3: glyph = 7'h4F;
			4'h4: glyph = 7'h66;
			4'h5: glyph = 7'h6D;
			4'h6: glyph = 7'h7D;
			4'h7: glyph = 7'h07;
			4'h8: glyph = 7'h7F;
			4'h9: glyph = 7'h6F;
			4'hA: glyph = 7'h77;
			4'hB: glyph = 7'h7C;
			4'hC: glyph = 7'h39;
			4'hD: glyph = 7'h5E;
			4'hE: glyph = 7'h79;
			default: glyph = 7'h71;
		endcase
	endfunction

	// right character of a message, shown on digit zero
	function automatic logic [6:0] msg_right(input logic [1:0] m);
		unique case (m)
			2'd0: msg_right = 7'h77;
			default: msg_right = 7'h00;
		endcase
	endfunction

	// left character of a message, shown on digit one
	function automatic logic [6:0] msg_left(input logic [1:0] m);
		unique case (m)
			2'd0: msg_left = 7'h76;
			2'd1: msg_left = 7'h08;
			2'd2: msg_left = 7'h01;
			default: msg_left = 7'h00;
		endcase
	endfunction

endpackage

[sv/ssnf_seq.sv]
module ssnf_seq
	import ssnf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output ctrl_t ctrl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [STEP_W-1:0] step_inc;
	logic [STEP_W-1:0] disp;
	cword_t            cw;
	logic              cond_true;

	function automatic cword_t ucode(input logic [STEP_W-1:0] a);
		unique case (a)
			A_LOAD:     ucode = '{OP_LOAD,    J_ACCEPT,   C_SPECIAL,     A_DISPATCH};
			A_DISPATCH: ucode = '{OP_NOP,     J_DISPATCH, C_SPECIAL,     A_BLANK};
			A_BLANK:    ucode = '{OP_BLANK,   J_COND,     C_SPECIAL,     A_SPECIAL};
			A_DIV:      ucode = '{OP_DIV,     J_COND,     C_DIV_MORE,    A_DIV};
			A_DIGIT:    ucode = '{OP_DIGIT,   J_COND,     C_MORE_DIGITS, A_DIV};
			A_FITCHK:   ucode = '{OP_NOP,     J_COND,     C_OVF,         A_OVF};
			A_SIGN:     ucode = '{OP_SIGN,    J_JUMP,     C_SPECIAL,     A_EMIT};
			A_OVF:      ucode = '{OP_OVF,     J_JUMP,     C_SPECIAL,     A_EMIT};
			A_SPECIAL:  ucode = '{OP_SPECIAL, J_JUMP,     C_SPECIAL,     A_EMIT};
			A_MESSAGE:  ucode = '{OP_MESSAGE, J_JUMP,     C_SPECIAL,     A_EMIT};
			A_LAMP:     ucode = '{OP_LAMP,    J_JUMP,     C_SPECIAL,     A_EMIT};
			A_CLEAR:    ucode = '{OP_CLEAR,   J_JUMP,     C_SPECIAL,     A_EMIT};
			A_SET_ERR:  ucode = '{OP_SET_ERR, J_JUMP,     C_SPECIAL,     A_EMIT};
			A_UNKNOWN:  ucode = '{OP_NOP,     J_JUMP,     C_SPECIAL,     A_EMIT};
			A_EMIT:     ucode = '{OP_EMIT,    J_EMIT,     C_SPECIAL,     A_LOAD};
			default:    ucode = '{OP_NOP,     J_JUMP,     C_SPECIAL,     A_LOAD};
		endcase
	endfunction

	assign cw       = ucode(step_q);
	assign in_ready = (cw.jmp == J_ACCEPT);
	assign step_inc = step_q + 1'b1;

	always_comb begin
		unique case (cw.cond)
			C_SPECIAL:     cond_true = stat.special;
			C_DIV_MORE:    cond_true = !stat.div_last;
			C_MORE_DIGITS: cond_true = stat.more_digits;
			default:       cond_true = stat.ovf;
		endcase
	end

	always_comb begin
		unique case (stat.req)
			REQ_SHOW:    disp = A_BLANK;
			REQ_MESSAGE: disp = A_MESSAGE;
			REQ_LAMP:    disp = A_LAMP;
			REQ_CLEAR:   disp = A_CLEAR;
			REQ_SET_ERR: disp = A_SET_ERR;
			default:     disp = A_UNKNOWN;
		endcase
	end

	always_comb begin
		ctrl.op   = cw.op;
		ctrl.fire = 1'b1;
		step_d    = step_inc;
		unique case (cw.jmp)
			J_NEXT: begin
				step_d = step_inc;
			end
			J_ACCEPT: begin
				ctrl.fire = in_valid;
				step_d    = in_valid ? step_inc : step_q;
			end
			J_DISPATCH: begin
				step_d = disp;
			end
			J_COND: begin
				step_d = cond_true ? cw.target : step_inc;
			end
			J_JUMP: begin
				step_d = cw.target;
			end
			default: begin
				ctrl.fire = !stat.out_full;
				step_d    = stat.out_full ? step_q : cw.target;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= A_LOAD;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

[sv/ssnf_div.sv]
module ssnf_div
	import ssnf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [NUM_W-1:0]  mag_in,
	input  logic              init,
	input  logic              step,
	input  logic [BASE_W-1:0] base,
	output logic [NUM_W-1:0]  mag,
	output logic [BASE_W-1:0] rem,
	output logic              last
);

	localparam int BITS_PER_STEP = 4;

	logic [NUM_W-1:0]  mag_q;
	logic [BASE_W-1:0] rem_q;
	logic [1:0]        cnt_q;
	logic [NUM_W-1:0]  mag_n;
	logic [BASE_W-1:0] rem_n;

	// restoring division, four quotient bits per cycle while step is asserted
	always_comb begin
		mag_n = mag_q;
		rem_n = rem_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			rem_n = {rem_n[BASE_W-2:0], mag_n[NUM_W-1]};
			mag_n = {mag_n[NUM_W-2:0], 1'b0};
			if (rem_n >= base) begin
				rem_n    = rem_n - base;
				mag_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (init) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= mag_in;
		end else if (step) begin
			mag_q <= mag_n;
		end
		if (init) begin
			rem_q <= '0;
		end else if (step) begin
			rem_q <= rem_n;
		end
	end

	assign mag  = mag_q;
	assign rem  = rem_q;
	assign last = (cnt_q == 2'd3);

endmodule

[sv/ssnf_dp.sv]
module ssnf_dp
	import ssnf_pkg::*;
#(
	parameter int DIGITS      = DIGITS_DEF,
	parameter int MINUS_DIGIT = MINUS_DIGIT_DEF,
	parameter int ERROR_DIGIT = ERROR_DIGIT_DEF,
	parameter int MESSAGES    = MESSAGES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_t                    ctrl,
	output stat_t                    stat,
	input  logic [REQ_W-1:0]         req_type,
	input  logic signed [NUM_W-1:0]  number,
	input  logic [BASE_W-1:0]        base,
	input  logic [MSG_W-1:0]         message_index,
	input  logic                     error_on,
	input  logic                     cfg_we,
	input  logic [CIDX_W-1:0]        cfg_index,
	input  logic [NUM_W-1:0]         cfg_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [15:0]              out_word,
	output logic                     out_ovf
);

	localparam int  IDX_W     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam bit  HAS_ERR   = (ERROR_DIGIT < DIGITS);
	localparam bit  HAS_MINUS = (MINUS_DIGIT < DIGITS);
	localparam logic [IDX_W-1:0] ERR_IDX   = IDX_W'(HAS_ERR ? ERROR_DIGIT : 0);
	localparam logic [IDX_W-1:0] MINUS_IDX = IDX_W'(HAS_MINUS ? MINUS_DIGIT : 0);
	localparam logic [IDX_W-1:0] HI_IDX    = IDX_W'((DIGITS > 1) ? 1 : 0);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DIGITS - 1);

	logic                    active_high_q;
	logic                    hex_digits_q;
	logic signed [NUM_W-1:0] guard_q;
	logic signed [NUM_W-1:0] code_one_min_q;
	logic signed [NUM_W-1:0] code_one_q_q;
	logic signed [NUM_W-1:0] code_all_min_q;

	logic [7:0]              buf_q [DIGITS];
	logic [7:0]              buf_d [DIGITS];
	logic signed [NUM_W-1:0] num_q;
	logic [REQ_W-1:0]        req_q;
	logic [MSG_W-1:0]        msg_q;
	logic                    eon_q;
	logic                    neg_q;
	logic                    special_q;
	logic [BASE_W-1:0]       base_q;
	logic                    err_q;
	logic                    ovf_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    out_valid_q;
	logic [15:0]             out_word_q;
	logic                    out_ovf_q;

	logic [BASE_W-1:0]       base_sat;
	logic [BASE_W-1:0]       base_max;
	logic [NUM_W-1:0]        mag_in;
	logic [NUM_W-1:0]        mag;
	logic [BASE_W-1:0]       rem;
	logic                    div_last;
	logic                    load;
	logic [7:0]              blank;
	logic [7:0]              minus;
	logic [7:0]              quest;

	assign load     = (ctrl.op == OP_LOAD) && ctrl.fire;
	assign base_max = hex_digits_q ? BASE_W'(16) : BASE_W'(10);
	assign base_sat = (base < BASE_W'(2)) ? BASE_W'(2) : ((base > base_max) ? base_max : base);
	assign mag_in   = number[NUM_W-1] ? NUM_W'(-number) : NUM_W'(number);
	assign blank    = polar(PAT_BLANK, active_high_q);
	assign minus    = polar(PAT_MINUS, active_high_q);
	assign quest    = polar(PAT_QUESTION, active_high_q);

	ssnf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.mag_in (mag_in),
		.init   ((ctrl.op == OP_BLANK) || (ctrl.op == OP_DIGIT)),
		.step   (ctrl.op == OP_DIV),
		.base   (base_q),
		.mag    (mag),
		.rem    (rem),
		.last   (div_last)
	);

	always_comb begin
		stat.special     = special_q;
		stat.div_last    = div_last;
		stat.more_digits = (mag != '0) && (idx_q != LAST_IDX);
		stat.ovf         = (mag != '0);
		stat.out_full    = out_valid_q && !out_ready;
		stat.req         = req_q;
	end

	always_comb begin
		buf_d = buf_q;
		unique case (ctrl.op)
			OP_BLANK: begin
				for (int i = 0; i < DIGITS; i++) buf_d[i] = blank;
			end
			OP_DIGIT: begin
				buf_d[idx_q] = polar(glyph(rem[3:0]), active_high_q);
			end
			OP_SIGN: begin
				if (HAS_MINUS && neg_q) buf_d[MINUS_IDX][7] = 1'b1;
				if (HAS_ERR) buf_d[ERR_IDX][7] = buf_d[ERR_IDX][7] | err_q;
			end
			OP_OVF: begin
				for (int i = 0; i < DIGITS; i++) buf_d[i] = minus;
			end
			OP_SPECIAL: begin
				if (num_q == code_one_min_q) begin
					buf_d[0] = minus;
				end else if (num_q == code_one_q_q) begin
					buf_d[0] = quest;
				end else if (num_q == code_all_min_q) begin
					for (int i = 0; i < DIGITS; i++) buf_d[i] = minus;
				end else begin
					for (int i = 0; i < DIGITS; i++) buf_d[i] = quest;
				end
				if (HAS_ERR) buf_d[ERR_IDX][7] = buf_d[ERR_IDX][7] | err_q;
			end
			OP_MESSAGE: begin
				if (int'(msg_q) < MESSAGES && msg_q < MSG_W'(4)) begin
					buf_d[0] = polar(msg_right(msg_q[1:0]), active_high_q);
					if (DIGITS > 1) buf_d[HI_IDX] = polar(msg_left(msg_q[1:0]), active_high_q);
				end
				if (HAS_ERR) buf_d[ERR_IDX][7] = buf_d[ERR_IDX][7] | err_q;
			end
			OP_LAMP: begin
				for (int i = 0; i < DIGITS; i++) buf_d[i] = polar(PAT_ALL, active_high_q) | 8'h80;
			end
			OP_CLEAR: begin
				for (int i = 0; i < DIGITS; i++) buf_d[i] = blank;
				if (HAS_ERR) buf_d[ERR_IDX][7] = err_q;
			end
			OP_SET_ERR: begin
				if (HAS_ERR) buf_d[ERR_IDX][7] = eon_q;
			end
			default: begin
				buf_d = buf_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) buf_q[i] <= '0;
			active_high_q  <= 1'b1;
			hex_digits_q   <= 1'b0;
			guard_q        <= 16'sd32000;
			code_one_min_q <= 16'sd32001;
			code_one_q_q   <= 16'sd32002;
			code_all_min_q <= 16'sd32003;
			out_valid_q    <= 1'b0;
			idx_q          <= '0;
			ovf_q          <= 1'b0;
		end else begin
			buf_q <= buf_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACTIVE_HIGH:   active_high_q  <= cfg_data[0];
					CFG_HEX_DIGITS:    hex_digits_q   <= cfg_data[0];
					CFG_SPECIAL_GUARD: guard_q        <= cfg_data;
					CFG_CODE_ONE_MIN:  code_one_min_q <= cfg_data;
					CFG_CODE_ONE_Q:    code_one_q_q   <= cfg_data;
					CFG_CODE_ALL_MIN:  code_all_min_q <= cfg_data;
					default: ;
				endcase
			end
			if (load) begin
				ovf_q <= 1'b0;
			end else if (ctrl.op == OP_OVF) begin
				ovf_q <= 1'b1;
			end
			if (ctrl.op == OP_BLANK) begin
				idx_q <= '0;
			end else if (ctrl.op == OP_DIGIT) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ctrl.op == OP_EMIT && ctrl.fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_q     <= number;
			req_q     <= req_type;
			msg_q     <= message_index;
			eon_q     <= error_on;
			neg_q     <= number[NUM_W-1];
			special_q <= (number > guard_q);
			base_q    <= base_sat;
			err_q     <= HAS_ERR ? buf_q[ERR_IDX][7] : 1'b0;
		end
		if (ctrl.op == OP_EMIT && ctrl.fire) begin
			out_word_q <= {(DIGITS > 1) ? buf_q[HI_IDX] : 8'h00, buf_q[0]};
			out_ovf_q  <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_ovf   = out_ovf_q;

endmodule

[sv/seven_segment_number_formatter.sv]
// Seven-segment number formatter. Each request on the slave stream updates a buffer of
// DIGITS segment bytes (segments a..g in bits 0..6, point in bit 7) and returns digits
// zero and one packed into m_axis_tdata, with tuser flagging an overflowing number.
// One request is handled at a time by a small microprogram. A non-number request passes
// through load, dispatch, its own step and emit. A number is first blanked; each digit is
// then produced by the shared divider, which retires four quotient bits a cycle, followed
// by a step to write the glyph; a special code goes from blanking to its pattern. A result
// waits in the output register while the next request is accepted. Configuration writes
// are taken every cycle and must only be issued while no request is in flight.
module seven_segment_number_formatter
	import ssnf_pkg::*;
#(
	parameter int DIGITS      = DIGITS_DEF,
	parameter int MINUS_DIGIT = MINUS_DIGIT_DEF,
	parameter int ERROR_DIGIT = ERROR_DIGIT_DEF,
	parameter int MESSAGES    = MESSAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,  // number, base, message_index, error_on
	input  logic [REQ_W-1:0]  s_axis_tuser,  // req_type
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,  // display_word
	output logic [0:0]        m_axis_tuser,  // overflowed
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [NUM_W-1:0]  cfg_data
);

	ctrl_t ctrl;
	stat_t stat;

	assign cfg_ready = 1'b1;

	ssnf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	ssnf_dp #(
		.DIGITS      (DIGITS),
		.MINUS_DIGIT (MINUS_DIGIT),
		.ERROR_DIGIT (ERROR_DIGIT),
		.MESSAGES    (MESSAGES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.req_type      (s_axis_tuser),
		.number        (s_axis_tdata[15:0]),
		.base          (s_axis_tdata[20:16]),
		.message_index (s_axis_tdata[23:21]),
		.error_on      (s_axis_tdata[24]),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_word      (m_axis_tdata),
		.out_ovf       (m_axis_tuser[0])
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while another is in flight");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result raised without a request being processed");

	a_ovf_no_points: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[7] && !m_axis_tdata[15])
		else $error("overflow result carries a lit point");

endmodule
